// ----- rtl/golay_18_6_8_header_decoder_assert.svh -----
// Assertion macros shared by the header decoder RTL.
// Depends on nothing; each macro takes its clock and active-low reset as arguments.
`ifndef GOLAY_18_6_8_HEADER_DECODER_ASSERT_SVH
`define GOLAY_18_6_8_HEADER_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("header decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("header decoder assertion failed");

`endif

// ----- rtl/ghd_pkg.sv -----
// Types, constants and the codeword function of the header decoder.
// Used by every module of the block; depends on nothing.
package ghd_pkg;

    localparam int WORD_W       = 18;
    localparam int HEXBIT_W     = 6;
    localparam int PARITY_W     = 12;
    localparam int DIST_W       = 5;
    localparam int CELLS        = 8;
    localparam int CANDS_PER_CELL = 8;
    localparam int GROUP_W      = 3;
    localparam int HEXBITS_KEPT = 8;
    localparam int FIELD_W      = HEXBIT_W * HEXBITS_KEPT;
    localparam int ALG_W        = 8;

    localparam logic [DIST_W-1:0] DIST_INIT = 5'd19;
    localparam logic [ALG_W-1:0]  UNENC_ALG_RESET = 8'd128;

    localparam logic [PARITY_W-1:0] PARITY_ROWS [HEXBIT_W] = '{
        12'hAE3, 12'hF92, 12'hD2B, 12'hC76, 12'hCD9, 12'h66D
    };

    typedef struct packed {
        logic [WORD_W-1:0]   rx;
        logic [HEXBIT_W-1:0] best;
        logic [DIST_W-1:0]   min_dist;
        logic                keep;
        logic                emit;
    } cell_bus_t;

    typedef struct packed {
        logic [HEXBIT_W-1:0] hexbit;
        logic                keep;
        logic                emit;
    } tail_bus_t;

    function automatic logic [WORD_W-1:0] make_codeword(input logic [HEXBIT_W-1:0] h);
        logic [PARITY_W-1:0] par;
        par = '0;
        for (int i = 0; i < HEXBIT_W; i++)
        begin
            if (h[HEXBIT_W-1-i])
            begin
                par = par ^ PARITY_ROWS[i];
            end
        end
        return {h, par};
    endfunction

endpackage

// ----- rtl/ghd_if.sv -----
// Handshake channels of the header decoder: received words in, header fields out.
// Depends on ghd_pkg for the field widths.
interface ghd_word_if;
    logic                         valid;
    logic                         ready;
    logic [ghd_pkg::WORD_W-1:0]   received_word;
    logic                         first;

    modport source (output valid, received_word, first, input ready);
    modport sink (input valid, received_word, first, output ready);
endinterface

interface ghd_hdr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  manufacturer_id;
    logic [7:0]  algorithm_id;
    logic [15:0] key_id;
    logic [15:0] talkgroup;
    logic        encrypted;

    modport source (output valid, manufacturer_id, algorithm_id, key_id, talkgroup,
                    encrypted, input ready);
    modport sink (input valid, manufacturer_id, algorithm_id, key_id, talkgroup,
                  encrypted, output ready);
endinterface

// ----- rtl/ghd_cell.sv -----
// One search cell: compares a word against eight candidate codewords and passes it on.
// Depends on ghd_pkg.
module ghd_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [ghd_pkg::GROUP_W-1:0]   group,
    input  logic                          prev_valid,
    input  ghd_pkg::cell_bus_t            prev_data,
    output logic                          valid_reg,
    output ghd_pkg::cell_bus_t            data_reg
);

    ghd_pkg::cell_bus_t data_next;

    always_comb
    begin
        logic [ghd_pkg::HEXBIT_W-1:0] h;
        logic [ghd_pkg::DIST_W-1:0]   d;
        data_next = prev_data;
        for (int j = 0; j < ghd_pkg::CANDS_PER_CELL; j++)
        begin
            h = {group, 3'(j)};
            d = ghd_pkg::DIST_W'($countones(ghd_pkg::make_codeword(h) ^ prev_data.rx));
            if (d < data_next.min_dist)
            begin
                data_next.min_dist = d;
                data_next.best     = h;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/ghd_assembler.sv -----
// Collects the last eight hexbits of a header and holds the result item for the receiver.
// Depends on ghd_pkg, ghd_if and the assertion macro header.
`include "golay_18_6_8_header_decoder_assert.svh"

module ghd_assembler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tail_valid,
    input  ghd_pkg::tail_bus_t          tail_data,
    input  logic [ghd_pkg::ALG_W-1:0]   unencrypted_algid,
    output logic                        advance,
    ghd_hdr_if.source                   hdr
);

    logic [ghd_pkg::FIELD_W-1:0] field_hexbits_reg;
    logic [ghd_pkg::FIELD_W-1:0] field_hexbits_next;
    logic                        out_valid_reg;
    logic                        load;

    assign advance = !(out_valid_reg && !hdr.ready && tail_valid && tail_data.emit);
    assign load = advance && tail_valid && tail_data.emit;

    always_comb
    begin
        field_hexbits_next = field_hexbits_reg;
        if (tail_valid && tail_data.keep)
        begin
            field_hexbits_next = {field_hexbits_reg[ghd_pkg::FIELD_W-ghd_pkg::HEXBIT_W-1:0],
                                  tail_data.hexbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_hexbits_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                field_hexbits_reg <= field_hexbits_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hdr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr.manufacturer_id <= field_hexbits_next[47:40];
            hdr.algorithm_id    <= field_hexbits_next[39:32];
            hdr.key_id          <= field_hexbits_next[31:16];
            hdr.talkgroup       <= field_hexbits_next[15:0];
            hdr.encrypted       <= (field_hexbits_next[39:32] != unencrypted_algid);
        end
    end

    assign hdr.valid = out_valid_reg;

    `GHD_ASSERT_NEXT(a_load_shows_item, clk, rst_n, load, out_valid_reg)
    `GHD_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid_reg && !hdr.ready, !load)
    `GHD_ASSERT_NEXT(a_hold_item, clk, rst_n, out_valid_reg && !hdr.ready, out_valid_reg && $stable(hdr.talkgroup))

endmodule

// ----- rtl/golay_18_6_8_header_decoder.sv -----
// Top level of the shortened Golay (18,6,8) header decoder.
// Depends on ghd_pkg, ghd_if, ghd_cell, ghd_assembler and the assertion macro header.
//
// Channel rx carries one 18-bit received word per item, first on-air bit in bit 17,
// plus a first flag that starts a header. Channel hdr carries one item per complete
// header of WORDS_PER_HEADER words: manufacturer, algorithm, key, talkgroup and an
// encrypted flag. Words with first low outside a header are dropped.
// wr_en and wr_data write the algorithm id that means no encryption.
// Each word is decoded by a row of eight search cells, each checking eight of the
// 64 candidates and registering its best match, so one item is taken every cycle unless hdr stalls the row.
// After its last word is accepted, the header item moves through the row: the first
// cell loads at the accepting edge, seven more cell stages follow, then the output register.
// Reset empties the cell row and the output, sets the block to wait for a first flag
// and sets the unencrypted algorithm id to 128.
// While a header item waits on hdr, the row keeps moving until the next header item
// reaches its end; only then does rx.ready go low, and it stays low until hdr.ready.
`include "golay_18_6_8_header_decoder_assert.svh"

module golay_18_6_8_header_decoder #(
    parameter int WORDS_PER_HEADER = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [ghd_pkg::ALG_W-1:0]  wr_data,
    ghd_word_if.sink                   rx,
    ghd_hdr_if.source                  hdr
);

    localparam int CNT_W     = $clog2(WORDS_PER_HEADER + 1);
    localparam int KEEP_FROM = WORDS_PER_HEADER - ghd_pkg::HEXBITS_KEPT;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          count_base;
    logic [ghd_pkg::ALG_W-1:0] unenc_alg_reg;
    logic                      advance;
    logic                      accept;
    logic                      take;

    logic                      chain_valid [ghd_pkg::CELLS+1];
    ghd_pkg::cell_bus_t        chain_data  [ghd_pkg::CELLS+1];
    ghd_pkg::tail_bus_t        tail_data;

    assign rx.ready = advance;
    assign accept = rx.valid && rx.ready;

    always_comb
    begin
        count_base = rx.first ? '0 : count_reg;
        take = accept && (rx.first || (count_reg < CNT_W'(WORDS_PER_HEADER)));
        count_next = take ? (count_base + CNT_W'(1)) : count_reg;
    end

    assign chain_valid[0]         = take;
    assign chain_data[0].rx       = rx.received_word;
    assign chain_data[0].best     = '0;
    assign chain_data[0].min_dist = ghd_pkg::DIST_INIT;
    assign chain_data[0].keep     = (count_base >= CNT_W'(KEEP_FROM));
    assign chain_data[0].emit     = (count_base == CNT_W'(WORDS_PER_HEADER - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(WORDS_PER_HEADER);
            unenc_alg_reg <= ghd_pkg::UNENC_ALG_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                unenc_alg_reg <= wr_data;
            end
        end
    end

    for (genvar i = 0; i < ghd_pkg::CELLS; i++)
    begin : g_cell
        ghd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .group      (ghd_pkg::GROUP_W'(i)),
            .prev_valid (chain_valid[i]),
            .prev_data  (chain_data[i]),
            .valid_reg  (chain_valid[i+1]),
            .data_reg   (chain_data[i+1])
        );
    end

    assign tail_data.hexbit = chain_data[ghd_pkg::CELLS].best;
    assign tail_data.keep   = chain_data[ghd_pkg::CELLS].keep;
    assign tail_data.emit   = chain_data[ghd_pkg::CELLS].emit;

    ghd_assembler u_assembler (
        .clk               (clk),
        .rst_n             (rst_n),
        .tail_valid        (chain_valid[ghd_pkg::CELLS]),
        .tail_data         (tail_data),
        .unencrypted_algid (unenc_alg_reg),
        .advance           (advance),
        .hdr               (hdr)
    );

    `GHD_ASSERT_NEXT(a_first_restarts, clk, rst_n, accept && rx.first, count_reg == CNT_W'(1))
    `GHD_ASSERT_NEXT(a_idle_drops, clk, rst_n, accept && !rx.first && (count_reg >= CNT_W'(WORDS_PER_HEADER)), !chain_valid[1] && $stable(count_reg))
    `GHD_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(WORDS_PER_HEADER))

endmodule
